// File: src/bnfa_pkg.sv
// Shared types and constants for the bitmap next-fit allocator.
package bnfa_pkg;

    // Field widths
    localparam int IDX_W        = 12;
    localparam int CNT_W        = 13;
    localparam int STATUS_W     = 3;
    localparam int CELL_TDATA_W = 16;
    localparam int RES_TDATA_W  = 32;
    localparam int RES_PAD_W    = RES_TDATA_W - IDX_W - CNT_W;

    // Reset value of the pool size register
    localparam logic [CNT_W-1:0] POOL_RESET = 13'd4096;

    // Request kinds carried in s_tuser
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DOUBLE   = 3'd2,
        ST_RANGE    = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHK,
        S_SCAN,
        S_F_MUL,
        S_F_RD,
        S_F_CHK,
        S_OUT
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;     // clear one bitmap word
        logic load;      // capture the request
        logic a_chk;     // allocate: full check, first read
        logic scan;      // allocate: examine one word
        logic f_mul;     // free: reciprocal multiply
        logic f_rd;      // free: split index, range check, read
        logic f_chk;     // free: test and clear the bit
        logic out_load;  // move result into the output register
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic full;
        logic found;
        logic scan_last;
        logic range_err;
        logic out_busy;
    } ctrl_sts_t;

endpackage

// File: src/bitmap_next_fit_allocator_unit.sv
// Allocate: request capture, full check and first read, then a scan, one bitmap word read
// per cycle through the single memory read port; free: multiply, split and read, bit test.
// Throughput: one request in flight; the next is accepted once the result is in the output
// register, which holds it while m_tready is low.
// Reset: aresetn low clears counters and search start, pool_size returns to 4096; a clearing
// pass over every bitmap word then zeroes the bitmap, s_tready low.
module bitmap_next_fit_allocator_unit #(
    parameter int MAX_CELLS = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration: pool_size
    input  logic                                 cfg_wen,
    input  logic [bnfa_pkg::CNT_W-1:0]           cfg_wdata,
    // Request channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bnfa_pkg::CELL_TDATA_W-1:0]    s_tdata,   // [11:0] cell_index, [15:12] zero
    input  logic [0:0]                           s_tuser,   // [0] op
    // Result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bnfa_pkg::RES_TDATA_W-1:0]     m_tdata,   // [11:0] granted_index,
                                                            // [24:12] free_count, [31:25] zero
    output logic [bnfa_pkg::STATUS_W-1:0]        m_tuser    // [2:0] status
);
    import bnfa_pkg::*;

    ctrl_cmd_t         cmd;
    ctrl_sts_t         sts;
    logic [IDX_W-1:0]  out_granted;
    status_t           out_status;
    logic [CNT_W-1:0]  out_free;

    bnfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser[0]),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    bnfa_datapath #(
        .MAX_CELLS (MAX_CELLS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .in_cell     (s_tdata[IDX_W-1:0]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_granted (out_granted),
        .out_status  (out_status),
        .out_free    (out_free)
    );

    // Result packing
    assign m_tdata = {{RES_PAD_W{1'b0}}, out_free, out_granted};
    assign m_tuser = out_status;

    // No request taken while the bitmap is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.clear |-> !s_tready)
        else $error("request accepted during clearing pass");

    // One request in flight: ready drops after each accepted transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted while one is in flight");

    // A failed request never reports a granted cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[IDX_W-1:0] == '0))
        else $error("granted index set on a failed request");

    // Output register is only loaded when its transaction cannot be lost
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

endmodule

// File: src/bnfa_ctrl.sv
// Controller state machine of the bitmap next-fit allocator.
module bnfa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 op,
    input  bnfa_pkg::ctrl_sts_t  sts,
    output logic                 s_tready,
    output bnfa_pkg::ctrl_cmd_t  cmd
);
    import bnfa_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (sts.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) state_next = (op == OP_FREE) ? S_F_MUL : S_A_CHK;
            end
            S_A_CHK: begin
                state_next = sts.full ? S_OUT : S_SCAN;
            end
            S_SCAN: begin
                if (sts.found || sts.scan_last) state_next = S_OUT;
            end
            S_F_MUL: begin
                state_next = S_F_RD;
            end
            S_F_RD: begin
                state_next = sts.range_err ? S_OUT : S_F_CHK;
            end
            S_F_CHK: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!sts.out_busy) state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_CLEAR: cmd.clear = 1'b1;
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_A_CHK: cmd.a_chk = 1'b1;
            S_SCAN:  cmd.scan  = 1'b1;
            S_F_MUL: cmd.f_mul = 1'b1;
            S_F_RD:  cmd.f_rd  = 1'b1;
            S_F_CHK: cmd.f_chk = 1'b1;
            S_OUT:   cmd.out_load = !sts.out_busy;
        endcase
    end

endmodule

// File: src/bnfa_datapath.sv
// Datapath of the bitmap next-fit allocator: bitmap memory, scan, counters, result.
module bnfa_datapath #(
    parameter int MAX_CELLS = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [bnfa_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic [bnfa_pkg::IDX_W-1:0]    in_cell,
    input  bnfa_pkg::ctrl_cmd_t           cmd,
    output bnfa_pkg::ctrl_sts_t           sts,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [bnfa_pkg::IDX_W-1:0]    out_granted,
    output bnfa_pkg::status_t             out_status,
    output logic [bnfa_pkg::CNT_W-1:0]    out_free
);
    import bnfa_pkg::*;

    localparam int MAP_WORDS = (MAX_CELLS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BO_W      = $clog2(WORD_BITS);
    localparam int POS_W     = CNT_W + 1;
    localparam int POOL_CAP  = (MAX_CELLS > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : MAX_CELLS;
    localparam logic [CNT_W-1:0] POOL_MAX = CNT_W'(POOL_CAP);
    // Index split by reciprocal multiply: exact for indexes below 2**CNT_W
    localparam int DIV_SH    = 24;
    localparam int RECIP_W   = DIV_SH + 1;
    localparam int PROD_W    = DIV_SH + CNT_W;
    localparam longint RECIP_INT = ((64'd1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);
    localparam logic [BO_W-1:0]    LAST_BIT = BO_W'(WORD_BITS - 1);

    // Bitmap memory
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WA_W-1:0]      rd_addr;
    logic                 wr_en;
    logic [WA_W-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Control state
    logic [CNT_W-1:0] pool_size_reg;
    logic [CNT_W-1:0] used_count_reg;
    logic [CNT_W-1:0] start_flat_reg;
    logic [WA_W-1:0]  start_word_reg;
    logic [BO_W-1:0]  start_bit_reg;
    logic [WA_W-1:0]  clr_addr_reg;
    logic             out_valid_reg;

    // Payload
    logic [IDX_W-1:0]  cell_reg;
    logic [WA_W-1:0]   p_word_reg;
    logic [BO_W-1:0]   p_bit_reg;
    logic [WA_W-1:0]   cur_word_reg;
    logic [POS_W-1:0]  cur_base_reg;
    logic              phase2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [WA_W-1:0]   q_reg;
    logic [BO_W-1:0]   bit_reg;
    logic [IDX_W-1:0]  res_granted_reg;
    status_t           res_status_reg;
    logic [IDX_W-1:0]  out_granted_reg;
    status_t           out_status_reg;
    logic [CNT_W-1:0]  out_free_reg;

    // Pool bounds and counts
    logic [CNT_W-1:0] pool;
    logic             full;
    logic [CNT_W-1:0] free_now;

    assign pool     = (pool_size_reg > POOL_MAX) ? POOL_MAX : pool_size_reg;
    assign full     = used_count_reg >= pool;
    assign free_now = (pool > used_count_reg) ? pool - used_count_reg : '0;

    // Search start: the cell after the last grant, wrapped into the pool
    logic [POS_W-1:0] start_inc;
    logic             p_wrap;
    logic [WA_W-1:0]  p_word_nx;
    logic [BO_W-1:0]  p_bit_nx;
    logic [POS_W-1:0] p_base_nx;

    assign start_inc = {1'b0, start_flat_reg} + POS_W'(1);
    assign p_wrap    = start_inc >= {1'b0, pool};
    assign p_word_nx = p_wrap ? '0 :
                       (start_bit_reg == LAST_BIT) ? start_word_reg + WA_W'(1) : start_word_reg;
    assign p_bit_nx  = (p_wrap || start_bit_reg == LAST_BIT) ? '0 : start_bit_reg + BO_W'(1);
    assign p_base_nx = POS_W'(p_word_nx) * POS_W'(WORD_BITS);

    // Word examination: eligible free bits and lowest-index encoder
    logic [POS_W-1:0]     lim;
    logic                 first_word;
    logic                 last_word;
    logic [WORD_BITS-1:0] free_vec;
    logic                 found;
    logic [BO_W-1:0]      enc;

    assign lim        = {1'b0, pool} - cur_base_reg;
    assign first_word = !phase2_reg && (cur_word_reg == p_word_reg);
    assign last_word  = phase2_reg && (cur_word_reg == p_word_reg);

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            free_vec[i] = !rdata_reg[i] && (POS_W'(i) < lim)
                          && !(first_word && (BO_W'(i) < p_bit_reg))
                          && !(last_word && (BO_W'(i) >= p_bit_reg));
        end
    end

    assign found = |free_vec;

    always_comb begin
        enc = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_vec[i]) enc = BO_W'(i);
        end
    end

    // Next word of the scan; phase two restarts at word 0
    logic [POS_W-1:0] next_base;
    logic             to_phase2;
    logic [WA_W-1:0]  scan_word_nx;
    logic [POS_W-1:0] scan_base_nx;
    logic [POS_W-1:0] grant_pos;

    assign next_base    = cur_base_reg + POS_W'(WORD_BITS);
    assign to_phase2    = !phase2_reg && (next_base >= {1'b0, pool});
    assign scan_word_nx = to_phase2 ? '0 : cur_word_reg + WA_W'(1);
    assign scan_base_nx = to_phase2 ? '0 : next_base;
    assign grant_pos    = cur_base_reg + POS_W'(enc);

    // Free index split into word and bit
    logic [PROD_W-1:0] prod_nx;
    logic [CNT_W-1:0]  q_full;
    logic [POS_W-1:0]  qw;
    logic [POS_W-1:0]  rem;
    logic              range_err;
    logic              bit_set;

    assign prod_nx   = PROD_W'(cell_reg) * PROD_W'(RECIP);
    assign q_full    = prod_reg[DIV_SH +: CNT_W];
    assign qw        = POS_W'(q_full) * POS_W'(WORD_BITS);
    assign rem       = POS_W'(cell_reg) - qw;
    assign range_err = {1'b0, cell_reg} >= pool;
    assign bit_set   = rdata_reg[bit_reg];

    // Memory port selection
    always_comb begin
        priority if (cmd.a_chk) begin
            rd_addr = p_word_nx;
        end else if (cmd.scan) begin
            rd_addr = scan_word_nx;
        end else if (cmd.f_rd) begin
            rd_addr = q_full[WA_W-1:0];
        end else begin
            rd_addr = cur_word_reg;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_word_reg;
        wr_data = rdata_reg;
        priority if (cmd.clear) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else if (cmd.scan && found) begin
            wr_en   = 1'b1;
            wr_data = rdata_reg | (WORD_BITS'(1) << enc);
        end else if (cmd.f_chk && bit_set) begin
            wr_en   = 1'b1;
            wr_addr = q_reg;
            wr_data = rdata_reg & ~(WORD_BITS'(1) << bit_reg);
        end
    end

    // Bitmap memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) map_mem[wr_addr] <= wr_data;
        rdata_reg <= map_mem[rd_addr];
    end

    // Control state: pool size, counts, search start, clear sweep, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg  <= POOL_RESET;
            used_count_reg <= '0;
            start_flat_reg <= '0;
            start_word_reg <= '0;
            start_bit_reg  <= '0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wen) pool_size_reg <= cfg_wdata;
            if (cmd.clear) clr_addr_reg <= clr_addr_reg + WA_W'(1);
            if (cmd.scan && found) begin
                used_count_reg <= used_count_reg + CNT_W'(1);
                start_flat_reg <= grant_pos[CNT_W-1:0];
                start_word_reg <= cur_word_reg;
                start_bit_reg  <= enc;
            end
            if (cmd.f_chk && bit_set && used_count_reg != '0) begin
                used_count_reg <= used_count_reg - CNT_W'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) cell_reg <= in_cell;
        if (cmd.a_chk) begin
            p_word_reg      <= p_word_nx;
            p_bit_reg       <= p_bit_nx;
            cur_word_reg    <= p_word_nx;
            cur_base_reg    <= p_base_nx;
            phase2_reg      <= 1'b0;
            res_granted_reg <= '0;
            res_status_reg  <= ST_FULL;
        end
        if (cmd.scan) begin
            if (found) begin
                res_granted_reg <= grant_pos[IDX_W-1:0];
                res_status_reg  <= ST_OK;
            end else if (last_word) begin
                res_granted_reg <= '0;
                res_status_reg  <= ST_MISMATCH;
            end else begin
                cur_word_reg <= scan_word_nx;
                cur_base_reg <= scan_base_nx;
                phase2_reg   <= phase2_reg | to_phase2;
            end
        end
        if (cmd.f_mul) prod_reg <= prod_nx;
        if (cmd.f_rd) begin
            q_reg           <= q_full[WA_W-1:0];
            bit_reg         <= rem[BO_W-1:0];
            res_granted_reg <= '0;
            res_status_reg  <= ST_RANGE;
        end
        if (cmd.f_chk) begin
            res_status_reg <= bit_set ? ST_OK : ST_DOUBLE;
        end
        if (cmd.out_load) begin
            out_granted_reg <= res_granted_reg;
            out_status_reg  <= res_status_reg;
            out_free_reg    <= free_now;
        end
    end

    // Status to controller
    assign sts.clear_last = clr_addr_reg == WA_W'(MAP_WORDS - 1);
    assign sts.full       = full;
    assign sts.found      = found;
    assign sts.scan_last  = last_word;
    assign sts.range_err  = range_err;
    assign sts.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid    = out_valid_reg;
    assign out_granted = out_granted_reg;
    assign out_status  = out_status_reg;
    assign out_free    = out_free_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the bitmap next-fit allocator unit.
module tb_top;
    import bnfa_pkg::*;

    // Pool sizes visited by the random phases, extremes included
    localparam int NUM_PHASES   = 14;
    localparam int PHASE_ITEMS  = 135;
    localparam int LAST_ITEMS   = 100;
    localparam int LIMIT_CYCLES = 1500000;

    typedef struct {
        logic             op;
        logic [IDX_W-1:0] cell_idx;
    } request_t;

    typedef struct {
        logic [IDX_W-1:0] grant;
        status_t          status;
        logic [CNT_W-1:0] free_cells;
    } reply_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wen = 1'b0;
    logic [CNT_W-1:0]        cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [CELL_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [RES_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]     m_tuser;

    // Allocator state as predicted
    bit [4095:0]      cell_used;
    logic [CNT_W-1:0] used_cells;
    logic [IDX_W-1:0] last_grant;
    logic [CNT_W-1:0] pool_reg;
    int               held_cells[$];

    request_t pending_requests[$];
    reply_t   expected_replies[$];
    request_t drive_req;
    reply_t   want;

    int  n_pushed, n_accepted, n_replies, err_cnt, n_settings;
    int  status_seen[5];
    bit  idle_on, quiet;
    int  send_gap, stall_left, hold_left;
    bit  hold_done;

    int pool_plan[NUM_PHASES] = '{1, 2, 7, 64, 65, 130, 4096, 17, 8191, 0, 300, 4095, 33, 5};

    bitmap_next_fit_allocator_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int pool_cells();
        return (pool_reg > 13'd4096) ? 4096 : int'(pool_reg);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("MISMATCH %s: got %0d expected %0d (reply %0d)", what, got, exp_val, n_replies);
        err_cnt++;
    endtask

    // Next-fit allocate / free on the predicted bitmap, queues the expected reply
    task automatic serve_request(input logic op, input logic [IDX_W-1:0] cell_idx);
        reply_t r;
        int     pool, pos, n, i;
        bit     found;
        pool = pool_cells();
        r.grant = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (int'(used_cells) >= pool) begin
                r.status = ST_FULL;
            end else begin
                pos = int'(last_grant) + 1;
                if (pos >= pool) pos = 0;
                found = 1'b0;
                for (n = 0; n < pool && !found; n++) begin
                    if (!cell_used[pos]) begin
                        found = 1'b1;
                    end else begin
                        pos++;
                        if (pos >= pool) pos = 0;
                    end
                end
                if (found) begin
                    cell_used[pos] = 1'b1;
                    used_cells = used_cells + 1'b1;
                    last_grant = pos[IDX_W-1:0];
                    r.grant = pos[IDX_W-1:0];
                    held_cells.push_back(pos);
                end else begin
                    r.status = ST_MISMATCH;
                end
            end
        end else begin
            if (int'(cell_idx) >= pool) begin
                r.status = ST_RANGE;
            end else if (!cell_used[cell_idx]) begin
                r.status = ST_DOUBLE;
            end else begin
                cell_used[cell_idx] = 1'b0;
                if (used_cells != 0) used_cells = used_cells - 1'b1;
                for (i = held_cells.size() - 1; i >= 0; i--)
                    if (held_cells[i] == int'(cell_idx)) held_cells.delete(i);
            end
        end
        r.free_cells = (pool > int'(used_cells)) ? CNT_W'(pool - int'(used_cells)) : '0;
        status_seen[int'(r.status)]++;
        expected_replies.push_back(r);
    endtask

    // Queue one request, keeping the driver's backlog short
    task automatic push_request(input logic op, input logic [IDX_W-1:0] cell_idx);
        request_t q;
        while (pending_requests.size() >= 2) @(negedge aclk);
        q.op = op;
        q.cell_idx = cell_idx;
        pending_requests.push_back(q);
        n_pushed++;
    endtask

    // Mostly allocates and frees of held cells; some stray and out-of-pool frees
    task automatic push_random();
        int pick, pool;
        pick = $urandom_range(0, 99);
        pool = pool_cells();
        if (pick < 50)
            push_request(OP_ALLOC, IDX_W'($urandom));
        else if (pick < 85 && held_cells.size() != 0)
            push_request(OP_FREE,
                IDX_W'(held_cells[$urandom_range(0, held_cells.size() - 1)]));
        else if (pick < 95 && pool > 0)
            push_request(OP_FREE, IDX_W'($urandom_range(0, pool - 1)));
        else
            push_request(OP_FREE, IDX_W'($urandom_range(0, 4095)));
    endtask

    // Wait until every request has been answered and the block has gone quiet
    task automatic wait_drained();
        while (n_accepted != n_pushed || expected_replies.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_pool_size(input int value);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        pool_reg = CNT_W'(value);
        n_settings++;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                drive_req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(CELL_TDATA_W-IDX_W){1'b0}}, drive_req.cell_idx};
                s_tuser <= drive_req.op;
                if (idle_on && !quiet && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 11);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, once, so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_replies >= 400) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    // Result receiver with random stall bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on each request transaction, check each reply transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                serve_request(s_tuser[0], s_tdata[IDX_W-1:0]);
                n_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    $display("MISMATCH reply %0d arrived with nothing expected", n_replies);
                    err_cnt++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_tdata[IDX_W-1:0] !== want.grant)
                        report_mismatch("granted_index", int'(m_tdata[IDX_W-1:0]),
                                        int'(want.grant));
                    if (m_tdata[IDX_W+CNT_W-1:IDX_W] !== want.free_cells)
                        report_mismatch("free_count", int'(m_tdata[IDX_W+CNT_W-1:IDX_W]),
                                        int'(want.free_cells));
                    if (m_tdata[RES_TDATA_W-1:IDX_W+CNT_W] !== '0)
                        report_mismatch("tdata padding",
                                        int'(m_tdata[RES_TDATA_W-1:IDX_W+CNT_W]), 0);
                    if (m_tuser !== want.status)
                        report_mismatch("status", int'(m_tuser), int'(want.status));
                end
                n_replies++;
            end
        end
    end

    // Watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus sequence
    initial begin
        cell_used = '0;
        used_cells = '0;
        last_grant = '0;
        pool_reg = POOL_RESET;
        idle_on = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Default pool: first grants, double frees, both index extremes
        push_request(OP_ALLOC, 12'd0);
        push_request(OP_ALLOC, 12'hFFF);
        push_request(OP_FREE, 12'd1);
        push_request(OP_FREE, 12'd1);
        push_request(OP_FREE, 12'd0);
        push_request(OP_FREE, 12'd4095);
        push_request(OP_ALLOC, 12'd0);
        // Shrunk pool: search start beyond the pool, range error, filling up
        wait_drained();
        set_pool_size(3);
        push_request(OP_ALLOC, 12'd0);
        push_request(OP_ALLOC, 12'd0);
        push_request(OP_ALLOC, 12'd0);
        push_request(OP_FREE, 12'd3);
        push_request(OP_FREE, 12'd4095);
        push_request(OP_FREE, 12'd2);
        push_request(OP_ALLOC, 12'd0);
        // Empty pool
        wait_drained();
        set_pool_size(0);
        push_request(OP_ALLOC, 12'd0);
        push_request(OP_FREE, 12'd0);
        // Oversized setting, clamped to the full pool
        wait_drained();
        set_pool_size(8191);
        push_request(OP_ALLOC, 12'd0);
        push_request(OP_FREE, 12'd4095);
        push_request(OP_FREE, 12'd1);

        // Random phases over a range of pool sizes
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            set_pool_size(pool_plan[p]);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) push_random();
        end

        // Closing phase with no idling on either side
        wait_drained();
        quiet = 1'b1;
        set_pool_size(40);
        repeat (LAST_ITEMS) push_random();

        wait_drained();
        repeat (80) @(posedge aclk);
        if (expected_replies.size() != 0) begin
            $display("MISMATCH %0d replies never arrived", expected_replies.size());
            err_cnt++;
        end
        $display("Ran %0d requests across %0d pool size settings, %0d replies checked",
                 n_accepted, n_settings, n_replies);
        $display("Statuses: ok %0d, full %0d, double free %0d, out of range %0d, mismatch %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/bnfa_pkg.sv
src/bnfa_ctrl.sv
src/bnfa_datapath.sv
src/bitmap_next_fit_allocator_unit.sv
tb/tb_top.sv
